// ===== rtl/edc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edc_pkg: shared types and constants for the epoch-to-date converter
// Word formats, pipeline control, register address and the divide-by-
// constant reciprocals used by the conversion stages.
// ---------------------------------------------------------------------------
package edc_pkg;

    localparam int OFFSET_W = 11;
    localparam int EPOCH_W  = 31;
    localparam int DAYS_W   = 15;
    localparam int SECS_W   = 17;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 32;

    typedef struct packed {
        logic                 mode;
        logic [EPOCH_W-1:0]   epoch_seconds;
    } t_in_word;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic       range_error;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic err;
    } t_pipe_ctl;

    localparam logic [ADDR_W-1:0] ADDR_ZONE_OFFSET = 2'd0;

    // Seconds per day is 2^7 * 675, so the day count is (t >> 7) / 675.
    localparam int            DAY_SHIFT   = 34;
    localparam int            DAY_DIV     = 675;
    localparam logic [24:0]   DAY_RECIP   =
        25'(((64'd1 << DAY_SHIFT) + DAY_DIV - 1) / DAY_DIV);
    localparam logic [31:0]   SECS_PER_DAY = 32'd86400;

    // Four-year cycles counted from 1968-01-01, which is a leap year.
    localparam int            CYC_SHIFT   = 26;
    localparam int            CYC_DIV     = 1461;
    localparam logic [15:0]   CYC_RECIP   =
        16'(((64'd1 << CYC_SHIFT) + CYC_DIV - 1) / CYC_DIV);
    localparam logic [14:0]   DAYS_PER_CYCLE = 15'(CYC_DIV);
    localparam logic [14:0]   DAYS_1968_TO_EPOCH = 15'd731;
    localparam logic [10:0]   CYC_YEAR1 = 11'd366;
    localparam logic [10:0]   CYC_YEAR2 = 11'd731;
    localparam logic [10:0]   CYC_YEAR3 = 11'd1096;
    localparam logic [7:0]    YEAR_1968 = 8'd68;

    localparam int            WD_SHIFT    = 18;
    localparam int            WD_DIV      = 7;
    localparam logic [15:0]   WD_RECIP    =
        16'(((64'd1 << WD_SHIFT) + WD_DIV - 1) / WD_DIV);
    localparam logic [14:0]   WD_DIV15    = 15'(WD_DIV);
    localparam logic [14:0]   WD_BIAS     = 15'd4;

    localparam int            HOUR_SHIFT  = 29;
    localparam int            HOUR_DIV    = 3600;
    localparam logic [17:0]   HOUR_RECIP  =
        18'(((64'd1 << HOUR_SHIFT) + HOUR_DIV - 1) / HOUR_DIV);
    localparam logic [16:0]   SECS_PER_HOUR = 17'(HOUR_DIV);

    localparam int            MIN_SHIFT   = 18;
    localparam int            MIN_DIV     = 60;
    localparam logic [12:0]   MIN_RECIP   =
        13'(((64'd1 << MIN_SHIFT) + MIN_DIV - 1) / MIN_DIV);
    localparam logic [11:0]   SECS_PER_MIN = 12'(MIN_DIV);

    localparam logic [8:0]    FEB28_YDAY  = 9'd58;
    localparam logic [8:0]    FEB29_YDAY  = 9'd59;

    // Days before the first of each month in a common year.
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/edc_cfg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edc_cfg: configuration register port
// APB-style slave holding the signed time-zone offset in minutes.
// ---------------------------------------------------------------------------
module edc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [edc_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [edc_pkg::DATA_W-1:0]      pwdata,
    output logic      [edc_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic      [edc_pkg::OFFSET_W-1:0]    o_zone
);

    logic [edc_pkg::OFFSET_W-1:0] r_zone;
    logic [edc_pkg::OFFSET_W-1:0] n_zone;
    logic                         wr_zone;

    assign wr_zone = psel && penable && pwrite && (paddr == edc_pkg::ADDR_ZONE_OFFSET);

    always_comb begin
        n_zone = r_zone;
        if (wr_zone) begin
            n_zone = pwdata[edc_pkg::OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else begin
            r_zone <= n_zone;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == edc_pkg::ADDR_ZONE_OFFSET) begin
            prdata = {{(edc_pkg::DATA_W-edc_pkg::OFFSET_W){r_zone[edc_pkg::OFFSET_W-1]}},
                      r_zone};
        end
    end

    assign pready = 1'b1;
    assign o_zone = r_zone;

endmodule
`default_nettype wire

// ===== rtl/edc_split.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edc_split: zone adjustment and day split
// Three stages: offset add with range check, day count by reciprocal
// multiply, and seconds within the day.
// ---------------------------------------------------------------------------
module edc_split (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire edc_pkg::t_in_word             i_data,
    input  wire logic [edc_pkg::OFFSET_W-1:0]  i_zone,
    output edc_pkg::t_pipe_ctl                 o_ctl,
    output logic      [edc_pkg::DAYS_W-1:0]    o_days,
    output logic      [edc_pkg::SECS_W-1:0]    o_secs
);

    // Stage 0: adjusted time.
    logic signed [16:0] zone_x;
    logic signed [16:0] offset;
    logic signed [32:0] adj;
    edc_pkg::t_pipe_ctl n0_ctl, r0_ctl;
    logic [30:0]        n0_t, r0_t;

    always_comb begin
        zone_x = 17'($signed(i_zone));
        offset = (zone_x <<< 6) - (zone_x <<< 2);
        adj    = $signed({2'b00, i_data.epoch_seconds})
               + (i_data.mode ? 33'(offset) : 33'sd0);
        n0_ctl.valid = i_accept;
        // Negative, or beyond the signed 32-bit range.
        n0_ctl.err   = adj[32] | adj[31];
        n0_t         = adj[30:0];
    end

    // Stage 1: day count.
    logic [48:0]        day_prod;
    edc_pkg::t_pipe_ctl r1_ctl;
    logic [30:0]        r1_t;
    logic [14:0]        n1_days, r1_days;

    always_comb begin
        day_prod = {25'b0, r0_t[30:7]} * {24'b0, edc_pkg::DAY_RECIP};
        n1_days  = day_prod[edc_pkg::DAY_SHIFT +: 15];
    end

    // Stage 2: seconds within the day.
    logic [31:0]        sec_full;
    edc_pkg::t_pipe_ctl r2_ctl;
    logic [14:0]        r2_days;
    logic [16:0]        n2_secs, r2_secs;

    always_comb begin
        sec_full = {1'b0, r1_t} - ({17'b0, r1_days} * edc_pkg::SECS_PER_DAY);
        n2_secs  = sec_full[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else begin
            r0_ctl <= n0_ctl;
            r1_ctl <= r0_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_t    <= n0_t;
        r1_t    <= r0_t;
        r1_days <= n1_days;
        r2_days <= r1_days;
        r2_secs <= n2_secs;
    end

    assign o_ctl  = r2_ctl;
    assign o_days = r2_days;
    assign o_secs = r2_secs;

endmodule
`default_nettype wire

// ===== rtl/edc_cal.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edc_cal: calendar date from day count
// Four stages: four-year cycle and weekday quotients, remainders, year
// within the cycle, then month and day of month from the month table.
// ---------------------------------------------------------------------------
module edc_cal (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire edc_pkg::t_pipe_ctl          i_ctl,
    input  wire logic [edc_pkg::DAYS_W-1:0]  i_days,
    output edc_pkg::t_pipe_ctl               o_ctl,
    output logic      [7:0]                  o_year,
    output logic      [8:0]                  o_yday,
    output logic      [3:0]                  o_month,
    output logic      [4:0]                  o_mday,
    output logic      [2:0]                  o_weekday
);

    // Stage 1: quotients by reciprocal multiply.
    logic [14:0] n1_d, n1_w;
    logic [30:0] cyc_prod, wd_prod;
    logic [4:0]  n1_cyc;
    logic [11:0] n1_wq;
    edc_pkg::t_pipe_ctl r1_ctl;
    logic [14:0] r1_d, r1_w;
    logic [4:0]  r1_cyc;
    logic [11:0] r1_wq;

    always_comb begin
        n1_d     = i_days + edc_pkg::DAYS_1968_TO_EPOCH;
        n1_w     = i_days + edc_pkg::WD_BIAS;
        cyc_prod = {16'b0, n1_d} * {15'b0, edc_pkg::CYC_RECIP};
        wd_prod  = {16'b0, n1_w} * {15'b0, edc_pkg::WD_RECIP};
        n1_cyc   = cyc_prod[edc_pkg::CYC_SHIFT +: 5];
        n1_wq    = wd_prod[edc_pkg::WD_SHIFT +: 12];
    end

    // Stage 2: remainders.
    logic [14:0] r_full, wd_full;
    logic [10:0] n2_r;
    logic [2:0]  n2_wd;
    edc_pkg::t_pipe_ctl r2_ctl;
    logic [10:0] r2_r;
    logic [4:0]  r2_cyc;
    logic [2:0]  r2_wd;

    always_comb begin
        r_full  = r1_d - (15'(r1_cyc) * edc_pkg::DAYS_PER_CYCLE);
        wd_full = r1_w - (15'(r1_wq) * edc_pkg::WD_DIV15);
        n2_r    = r_full[10:0];
        n2_wd   = wd_full[2:0];
    end

    // Stage 3: year within the cycle; its first year is the leap year.
    // Within 1970..2038 every fourth year is leap, 2000 included.
    logic [1:0]  yi;
    logic [10:0] ybase, yday_full;
    logic [8:0]  n3_yday;
    logic [7:0]  n3_year;
    logic        n3_leap;
    edc_pkg::t_pipe_ctl r3_ctl;
    logic [8:0]  r3_yday;
    logic [7:0]  r3_year;
    logic        r3_leap;
    logic [2:0]  r3_wd;

    always_comb begin
        if (r2_r >= edc_pkg::CYC_YEAR3) begin
            yi    = 2'd3;
            ybase = edc_pkg::CYC_YEAR3;
        end else if (r2_r >= edc_pkg::CYC_YEAR2) begin
            yi    = 2'd2;
            ybase = edc_pkg::CYC_YEAR2;
        end else if (r2_r >= edc_pkg::CYC_YEAR1) begin
            yi    = 2'd1;
            ybase = edc_pkg::CYC_YEAR1;
        end else begin
            yi    = 2'd0;
            ybase = '0;
        end
        yday_full = r2_r - ybase;
        n3_yday   = yday_full[8:0];
        n3_leap   = (yi == 2'd0);
        n3_year   = edc_pkg::YEAR_1968 + {1'b0, r2_cyc, 2'b00} + {6'b0, yi};
    end

    // Stage 4: month and day of month.
    logic [8:0]  work, mday_full;
    logic        feb29;
    logic [3:0]  n4_month;
    logic [4:0]  n4_mday;
    edc_pkg::t_pipe_ctl r4_ctl;
    logic [8:0]  r4_yday;
    logic [7:0]  r4_year;
    logic [3:0]  r4_month;
    logic [4:0]  r4_mday;
    logic [2:0]  r4_wd;

    always_comb begin
        feb29 = r3_leap && (r3_yday == edc_pkg::FEB29_YDAY);
        work  = (r3_leap && (r3_yday > edc_pkg::FEB28_YDAY)) ? r3_yday - 9'd1 : r3_yday;
        n4_month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (edc_pkg::cum_days(4'(m)) <= work) begin
                n4_month = 4'(m);
            end
        end
        mday_full = 9'd1 + {8'b0, feb29} + work - edc_pkg::cum_days(n4_month);
        n4_mday   = mday_full[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d     <= n1_d;
        r1_w     <= n1_w;
        r1_cyc   <= n1_cyc;
        r1_wq    <= n1_wq;
        r2_r     <= n2_r;
        r2_cyc   <= r1_cyc;
        r2_wd    <= n2_wd;
        r3_yday  <= n3_yday;
        r3_year  <= n3_year;
        r3_leap  <= n3_leap;
        r3_wd    <= r2_wd;
        r4_yday  <= r3_yday;
        r4_year  <= r3_year;
        r4_month <= n4_month;
        r4_mday  <= n4_mday;
        r4_wd    <= r3_wd;
    end

    assign o_ctl     = r4_ctl;
    assign o_year    = r4_year;
    assign o_yday    = r4_yday;
    assign o_month   = r4_month;
    assign o_mday    = r4_mday;
    assign o_weekday = r4_wd;

endmodule
`default_nettype wire

// ===== rtl/edc_tod.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edc_tod: time of day from seconds within the day
// Four stages matched to the calendar path: hour quotient, hour remainder,
// minute quotient, minute remainder.
// ---------------------------------------------------------------------------
module edc_tod (
    input  wire logic                        i_clk,
    input  wire logic [edc_pkg::SECS_W-1:0]  i_secs,
    output logic      [4:0]                  o_hour,
    output logic      [5:0]                  o_minute,
    output logic      [5:0]                  o_second
);

    logic [34:0] hour_prod;
    logic [4:0]  n1_hour, r1_hour;
    logic [16:0] r1_secs;

    logic [16:0] rem_full;
    logic [11:0] n2_rem, r2_rem;
    logic [4:0]  r2_hour;

    logic [24:0] min_prod;
    logic [5:0]  n3_min, r3_min;
    logic [11:0] r3_rem;
    logic [4:0]  r3_hour;

    logic [11:0] sec_full;
    logic [5:0]  n4_sec, r4_sec, r4_min;
    logic [4:0]  r4_hour;

    always_comb begin
        hour_prod = {18'b0, i_secs} * {17'b0, edc_pkg::HOUR_RECIP};
        n1_hour   = hour_prod[edc_pkg::HOUR_SHIFT +: 5];
        rem_full  = r1_secs - (17'(r1_hour) * edc_pkg::SECS_PER_HOUR);
        n2_rem    = rem_full[11:0];
        min_prod  = {13'b0, r2_rem} * {12'b0, edc_pkg::MIN_RECIP};
        n3_min    = min_prod[edc_pkg::MIN_SHIFT +: 6];
        sec_full  = r3_rem - (12'(r3_min) * edc_pkg::SECS_PER_MIN);
        n4_sec    = sec_full[5:0];
    end

    always_ff @(posedge i_clk) begin
        r1_secs <= i_secs;
        r1_hour <= n1_hour;
        r2_rem  <= n2_rem;
        r2_hour <= r1_hour;
        r3_rem  <= r2_rem;
        r3_min  <= n3_min;
        r3_hour <= r2_hour;
        r4_sec  <= n4_sec;
        r4_min  <= r3_min;
        r4_hour <= r3_hour;
    end

    assign o_hour   = r4_hour;
    assign o_minute = r4_min;
    assign o_second = r4_sec;

endmodule
`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_date_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit: epoch seconds to calendar date
// Converts a seconds count since 1970-01-01 to time of day and date.
// ---------------------------------------------------------------------------
// Usage:
//   An input word (mode, epoch_seconds) is taken at each rising edge with
//   start high and busy low. busy is high only while reset is held, so a new
//   word can be given in every cycle: one word per cycle sustained.
//   Each result word appears on o_data with o_done high for one cycle,
//   after its input has passed the seven register stages: zone add, day
//   quotient, seconds of day, then four stages in which the calendar and
//   time-of-day paths run side by side.
//   In local mode the zone offset register (APB address 0, signed minutes)
//   is added first. An adjusted time that is negative or above the signed
//   32-bit range gives range_error with all other fields zero.
//   The receiver has no way to stall the block; results are never held.
//   Reset clears the pipeline valid bits and sets the zone offset to zero;
//   words in flight at reset are dropped.
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire edc_pkg::t_in_word             i_data,
    output logic                               o_done,
    output edc_pkg::t_out_word                 o_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [edc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [edc_pkg::DATA_W-1:0]    pwdata,
    output logic      [edc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [edc_pkg::OFFSET_W-1:0] zone;
    logic                         accept;
    edc_pkg::t_pipe_ctl           split_ctl, cal_ctl;
    logic [edc_pkg::DAYS_W-1:0]   days;
    logic [edc_pkg::SECS_W-1:0]   secs;
    logic [7:0]                   year;
    logic [8:0]                   yday;
    logic [3:0]                   month;
    logic [4:0]                   mday;
    logic [2:0]                   weekday;
    logic [4:0]                   hour;
    logic [5:0]                   minute;
    logic [5:0]                   second;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    edc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_zone  (zone)
    );

    edc_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .i_zone   (zone),
        .o_ctl    (split_ctl),
        .o_days   (days),
        .o_secs   (secs)
    );

    edc_cal u_cal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (split_ctl),
        .i_days    (days),
        .o_ctl     (cal_ctl),
        .o_year    (year),
        .o_yday    (yday),
        .o_month   (month),
        .o_mday    (mday),
        .o_weekday (weekday)
    );

    edc_tod u_tod (
        .i_clk    (i_clk),
        .i_secs   (secs),
        .o_hour   (hour),
        .o_minute (minute),
        .o_second (second)
    );

    assign o_done = cal_ctl.valid;

    always_comb begin
        o_data = '0;
        o_data.range_error = cal_ctl.err;
        if (!cal_ctl.err) begin
            o_data.second           = second;
            o_data.minute           = minute;
            o_data.hour             = hour;
            o_data.day_of_month     = mday;
            o_data.month_index      = month;
            o_data.years_since_1900 = year;
            o_data.weekday          = weekday;
            o_data.day_of_year      = yday;
        end
    end

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##7 o_done)
        else $error("accepted word did not produce a result after seven cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 7))
        else $error("result without a matching accepted word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_data.range_error |->
            o_data.day_of_month == 5'd0 && o_data.years_since_1900 == 8'd0 &&
            o_data.hour == 5'd0 && o_data.day_of_year == 9'd0)
        else $error("date fields not cleared on range error");

    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_data.range_error |->
            o_data.day_of_month != 5'd0 && o_data.month_index <= 4'd11 &&
            o_data.years_since_1900 >= 8'd70 && o_data.hour <= 5'd23 &&
            o_data.minute <= 6'd59 && o_data.second <= 6'd59)
        else $error("converted date out of range");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for epoch_seconds_to_calendar_date_unit
// Sends epoch-second words in UTC and local mode and predicts every date
// word. The zone offset register is written and read back between phases,
// at its legal extremes, at the 11-bit extremes and at random values.
// Directed words cover the epoch, the top of the range, leap days, year ends
// and zone-induced range errors. Random words follow, with random gaps.
// ---------------------------------------------------------------------------
module tb;

    localparam longint DAY_SECS   = 86400;
    localparam longint EPOCH_YEAR = 1970;
    localparam longint TOP_SECS   = 64'h7FFF_FFFF;
    localparam int     PHASES     = 7;
    localparam int     RAND_WORDS = 80;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic                          busy;
    edc_pkg::t_in_word             i_data  = '0;
    logic                          o_done;
    edc_pkg::t_out_word            o_data;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [edc_pkg::ADDR_W-1:0]    paddr   = '0;
    logic [edc_pkg::DATA_W-1:0]    pwdata  = '0;
    logic [edc_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    edc_pkg::t_in_word  pending_words[$];
    edc_pkg::t_out_word date_expect_q[$];

    int  days_before_month[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int  zone_minutes = 0;
    bit  no_gaps      = 1'b0;
    bit  took_word    = 1'b0;
    int  gap_left     = 0;
    int  fail_count   = 0;
    int  utc_words    = 0;
    int  local_words  = 0;
    int  range_errors = 0;
    int  leap_days    = 0;
    int  zone_writes  = 0;

    epoch_seconds_to_calendar_date_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_done  (o_done),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Gregorian helpers; day counts are whole days from 1970-01-01, secs_of_date gives seconds.
    function automatic longint leap_days_before(input longint yr);
        longint p;
        p = yr - 1;
        return p / 4 - p / 100 + p / 400;
    endfunction

    function automatic longint year_first_day(input longint yr);
        return 365 * (yr - EPOCH_YEAR) + leap_days_before(yr) - leap_days_before(EPOCH_YEAR);
    endfunction

    function automatic bit leap_year(input longint yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic longint secs_of_date(input longint yr, input int mon, input int mday,
                                            input int hh, input int mm, input int ss);
        longint days;
        days = year_first_day(yr) + days_before_month[mon] + mday - 1;
        if (leap_year(yr) && mon > 1) begin
            days = days + 1;
        end
        return days * DAY_SECS + hh * 3600 + mm * 60 + ss;
    endfunction

    function automatic edc_pkg::t_out_word predict_date(input logic local_mode,
                                                        input logic [30:0] secs,
                                                        input int zone);
        edc_pkg::t_out_word r;
        longint adj, days, sod, yr, yday, work, mday;
        int mon;
        r = '0;
        adj = longint'(secs);
        if (local_mode) begin
            adj = adj + longint'(zone) * 60;
        end
        if (adj < 0 || adj > TOP_SECS) begin
            r.range_error = 1'b1;
            return r;
        end
        days = adj / DAY_SECS;
        sod  = adj % DAY_SECS;
        // The estimate from 365-day years can only run ahead, by two at most.
        yr = EPOCH_YEAR + days / 365;
        if (year_first_day(yr) > days) yr = yr - 1;
        if (year_first_day(yr) > days) yr = yr - 1;
        yday = days - year_first_day(yr);
        work = yday;
        mday = 1;
        // Fold the leap day back onto a common-year table; Feb 29 lands on Feb 28 + 1.
        if (leap_year(yr) && work > 58) begin
            if (work == 59) mday = 2;
            work = work - 1;
        end
        mon = 11;
        while (mon > 0 && days_before_month[mon] > work) mon = mon - 1;
        mday = mday + work - days_before_month[mon];
        r.second           = 6'(sod % 60);
        r.minute           = 6'((sod / 60) % 60);
        r.hour             = 5'(sod / 3600);
        r.day_of_month     = 5'(mday);
        r.month_index      = 4'(mon);
        r.years_since_1900 = 8'(yr - 1900);
        r.weekday          = 3'((4 + days) % 7);
        r.day_of_year      = 9'(yday);
        return r;
    endfunction

    function automatic string show_date(input edc_pkg::t_out_word d);
        return $sformatf("y=%0d mon=%0d mday=%0d %0d:%0d:%0d wd=%0d yday=%0d err=%0d",
                         d.years_since_1900, d.month_index, d.day_of_month, d.hour,
                         d.minute, d.second, d.weekday, d.day_of_year, d.range_error);
    endfunction

    function automatic int pick_gap();
        if (no_gaps) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 0;
            6, 7, 8:          return $urandom_range(1, 3);
            default:          return $urandom_range(5, 30);
        endcase
    endfunction

    // Mixes full-range values with values near the ends of the range,
    // around New Year and around the end of February.
    function automatic logic [30:0] pick_epoch();
        longint t;
        longint yr;
        yr = EPOCH_YEAR + $urandom_range(0, 67);
        case ($urandom_range(0, 5))
            0, 1:    t = longint'($urandom() & 32'h7FFF_FFFF);
            2:       t = longint'($urandom_range(0, 200000));
            3:       t = TOP_SECS - longint'($urandom_range(0, 200000));
            4:       t = secs_of_date(yr, 0, 1, 0, 0, 0)
                         + longint'($urandom_range(0, 345600)) - 172800;
            default: t = secs_of_date(yr, 1, 28, 0, 0, 0) + longint'($urandom_range(0, 259200));
        endcase
        if (t < 0) t = 0;
        if (t > TOP_SECS) t = TOP_SECS;
        return t[30:0];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("tb: ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic push_word(input logic local_mode, input longint secs);
        edc_pkg::t_in_word w;
        w.mode = local_mode;
        w.epoch_seconds = secs[30:0];
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || date_expect_q.size() != 0 || start) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    // Write the offset, then read it back; both are transfers with a setup and an access phase.
    task automatic write_zone_offset(input int minutes);
        logic [10:0] raw;
        raw = 11'(minutes);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= edc_pkg::ADDR_ZONE_OFFSET;
        pwdata  <= {{21{raw[10]}}, raw};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[10:0] !== raw) begin
            note_failure($sformatf("zone offset read back %0h, wrote %0h", prdata[10:0], raw));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        zone_minutes = minutes;
        zone_writes++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took_word) begin
            // The word on the bus has not been taken yet; keep it there.
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
            i_data   <= pending_words.pop_front();
            start    <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        edc_pkg::t_out_word want;
        took_word <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            date_expect_q.push_back(predict_date(i_data.mode, i_data.epoch_seconds,
                                                 zone_minutes));
            if (i_data.mode) local_words++;
            else utc_words++;
        end
        if (i_rst_n && o_done === 1'b1) begin
            if (date_expect_q.size() == 0) begin
                note_failure($sformatf("date word with none expected: %s", show_date(o_data)));
            end else begin
                want = date_expect_q.pop_front();
                if (o_data.range_error) range_errors++;
                if (o_data.month_index == 4'd1 && o_data.day_of_month == 5'd29) leap_days++;
                if (o_data.second !== want.second || o_data.minute !== want.minute
                    || o_data.hour !== want.hour || o_data.day_of_month !== want.day_of_month
                    || o_data.month_index !== want.month_index
                    || o_data.years_since_1900 !== want.years_since_1900
                    || o_data.weekday !== want.weekday
                    || o_data.day_of_year !== want.day_of_year
                    || o_data.range_error !== want.range_error) begin
                    note_failure($sformatf("expected %s, got %s",
                                           show_date(want), show_date(o_data)));
                end
            end
        end
    end

    initial begin
        int zone;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zone offset still at its reset value of zero.
        push_word(1'b0, 0);
        push_word(1'b1, 0);
        push_word(1'b0, TOP_SECS);
        push_word(1'b1, TOP_SECS);
        push_word(1'b0, secs_of_date(1970, 11, 31, 23, 59, 59));
        push_word(1'b0, secs_of_date(1972, 1, 28, 23, 59, 59));
        push_word(1'b0, secs_of_date(1972, 1, 29, 0, 0, 0));
        push_word(1'b1, secs_of_date(1972, 2, 1, 0, 0, 0));
        push_word(1'b0, secs_of_date(1972, 11, 31, 12, 0, 0));
        push_word(1'b0, secs_of_date(1999, 11, 31, 23, 59, 59));
        push_word(1'b0, secs_of_date(2000, 0, 1, 0, 0, 0));
        push_word(1'b0, secs_of_date(2000, 1, 29, 6, 30, 15));
        push_word(1'b0, secs_of_date(2000, 2, 1, 0, 0, 0));
        push_word(1'b0, secs_of_date(2001, 1, 28, 23, 59, 59));
        push_word(1'b0, secs_of_date(2001, 2, 1, 0, 0, 0));
        push_word(1'b1, secs_of_date(2037, 11, 31, 23, 59, 59));
        repeat (60) push_word(1'($urandom_range(0, 1)), pick_epoch());

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       zone = -720;
                1:       zone = 840;
                2:       zone = -1024;
                3:       zone = 1023;
                6:       zone = 0;
                default: zone = $urandom_range(0, 1560) - 720;
            endcase
            // The sender holds off here until every date word is back.
            wait_idle();
            write_zone_offset(zone);
            no_gaps = (p % 3 == 1);
            if (p == 0) begin
                // West of UTC the first half day after the epoch is out of range.
                push_word(1'b1, 0);
                push_word(1'b1, 43199);
                push_word(1'b1, 43200);
                push_word(1'b0, 0);
            end else if (p == 1) begin
                // East of UTC the top of the range overflows.
                push_word(1'b1, TOP_SECS);
                push_word(1'b1, TOP_SECS - 50400);
                push_word(1'b1, TOP_SECS - 50399);
            end
            repeat (RAND_WORDS) push_word(1'($urandom_range(0, 1)), pick_epoch());
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (date_expect_q.size() != 0) begin
            note_failure($sformatf("%0d date words never arrived", date_expect_q.size()));
        end
        $display("tb: %0d words checked (%0d UTC, %0d local), %0d out of range, %0d on Feb 29",
                 utc_words + local_words, utc_words, local_words, range_errors, leap_days);
        $display("tb: %0d zone offsets written, from -1024 to 1023 minutes; %0d failures",
                 zone_writes, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
